@@ hdl/e2lc_pkg.sv @@
// Shared types, constants and the control program for the epoch-to-calendar block.
// Used by e2lc_seq, e2lc_dp and epoch_to_local_calendar_top; depends on nothing else.
package e2lc_pkg;

  // Field widths.
  localparam int EpochW = 32;
  localparam int DayOffW = 9;
  localparam int ZoneW = 7;
  localparam int YearW = 12;
  localparam int PcW = 4;

  // Calendar constants.
  localparam logic signed [17:0] DAY_SECS = 18'sd86400;
  localparam logic signed [12:0] ZONE_UNIT_SECS = 13'sd900;
  localparam logic [16:0] DIV_DAY_VAL = 17'd86400;
  localparam logic [16:0] DIV_WEEK_VAL = 17'd7;
  localparam logic [16:0] DIV_HOUR_VAL = 17'd3600;
  localparam logic [16:0] DIV_MIN_VAL = 17'd60;
  localparam logic [YearW-1:0] BASE_YEAR = 12'd1970;
  localparam logic [15:0] WEEKDAY_BIAS = 16'd3;

  // Reciprocals for exact division by multiply and shift. The day divide works on the
  // count shifted right by 7 (86400 = 128 * 675), the hour divide on the second of the
  // day shifted right by 4 (3600 = 16 * 225) and the minute divide on the second of the
  // hour shifted right by 2 (60 = 4 * 15). Each constant is a power of two over the odd
  // factor, rounded up, and is exact over the whole range its dividend can take.
  localparam logic [25:0] RECIP_DAY = 26'd50903317;
  localparam logic [25:0] RECIP_WEEK = 26'd74899;
  localparam logic [25:0] RECIP_HOUR = 26'd9321;
  localparam logic [25:0] RECIP_MIN = 26'd1093;

  // Datapath operations, one per control word.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_ADDZ,
    OP_DIV,
    OP_DAYS,
    OP_WDAY,
    OP_HOUR,
    OP_MINSEC,
    OP_YEAR,
    OP_MONTH,
    OP_EMIT
  } op_t;

  // Divisor selection for the shared reciprocal divider.
  typedef enum logic [1:0] {
    DIV_DAY,
    DIV_WEEK,
    DIV_HOUR,
    DIV_MIN
  } div_sel_t;

  // Jump conditions: when true the step counter loads jump_pc, else it advances.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_GE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t             op;
    div_sel_t        div_sel;
    cond_t           cond;
    logic [PcW-1:0]  jump_pc;
  } ctrl_word_t;

  typedef struct packed {
    logic ge;
    logic out_busy;
  } status_t;

  // Control program.
  function automatic ctrl_word_t rom_word(input logic [PcW-1:0] pc);
    ctrl_word_t w;
    w = '{op: OP_NOP, div_sel: DIV_DAY, cond: COND_ALWAYS, jump_pc: '0};
    case (pc)
      4'd0: w = '{OP_LOAD,   DIV_DAY,  COND_NO_START, 4'd0};
      4'd1: w = '{OP_ADDZ,   DIV_DAY,  COND_NEVER,    4'd0};
      4'd2: w = '{OP_DIV,    DIV_DAY,  COND_NEVER,    4'd0};
      4'd3: w = '{OP_DAYS,   DIV_DAY,  COND_NEVER,    4'd0};
      4'd4: w = '{OP_DIV,    DIV_WEEK, COND_NEVER,    4'd0};
      4'd5: w = '{OP_WDAY,   DIV_WEEK, COND_NEVER,    4'd0};
      4'd6: w = '{OP_DIV,    DIV_HOUR, COND_NEVER,    4'd0};
      4'd7: w = '{OP_HOUR,   DIV_HOUR, COND_NEVER,    4'd0};
      4'd8: w = '{OP_DIV,    DIV_MIN,  COND_NEVER,    4'd0};
      4'd9: w = '{OP_MINSEC, DIV_MIN,  COND_NEVER,    4'd0};
      4'd10: w = '{OP_YEAR,  DIV_DAY,  COND_GE,       4'd10};
      4'd11: w = '{OP_MONTH, DIV_DAY,  COND_GE,       4'd11};
      4'd12: w = '{OP_EMIT,  DIV_DAY,  COND_OUT_BUSY, 4'd12};
      default: w = '{OP_NOP, DIV_DAY,  COND_ALWAYS,   4'd0};
    endcase
    return w;
  endfunction

  // Length of a month; every fourth year is a leap year.
  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd2: len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

@@ hdl/e2lc_seq.sv @@
// Microcode sequencer: step counter, program table and jump logic.
// Depends on e2lc_pkg.
module e2lc_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  e2lc_pkg::status_t   status,
  output e2lc_pkg::ctrl_word_t ctrl
);
  import e2lc_pkg::*;

  logic [PcW-1:0] pc;
  logic [PcW-1:0] pc_next;
  logic           take;

  // Fetch the control word of the current step.
  assign ctrl = rom_word(pc);

  // Evaluate the jump condition.
  always_comb begin
    case (ctrl.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_START: take = ~in_valid;
      COND_GE:       take = status.ge;
      COND_OUT_BUSY: take = status.out_busy;
      default:       take = 1'b1;
    endcase
  end

  assign pc_next = take ? ctrl.jump_pc : pc + 1'b1;

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

@@ hdl/e2lc_dp.sv @@
// Datapath: time shift, shared reciprocal divider, year and month walk, output register.
// Depends on e2lc_pkg; driven by the control words of e2lc_seq.
module e2lc_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  e2lc_pkg::ctrl_word_t                  ctrl,
  output e2lc_pkg::status_t                     status,
  input  logic                                  cfg_valid,
  input  logic signed [e2lc_pkg::ZoneW-1:0]     zone_offset,
  input  logic                                  in_valid,
  input  logic [e2lc_pkg::EpochW-1:0]           epoch_seconds,
  input  logic signed [e2lc_pkg::DayOffW-1:0]   day_offset,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [e2lc_pkg::YearW-1:0]            year,
  output logic [3:0]                            month,
  output logic [4:0]                            day,
  output logic [4:0]                            hour,
  output logic [5:0]                            minute,
  output logic [5:0]                            second,
  output logic [2:0]                            weekday
);
  import e2lc_pkg::*;

  logic signed [ZoneW-1:0] zone;
  logic [EpochW-1:0]       rem;
  logic [15:0]             quo;
  logic [15:0]             days;
  logic [16:0]             secs;
  logic [YearW-1:0]        yr_acc;
  logic [3:0]              mon_acc;
  logic [4:0]              hour_acc;
  logic [5:0]              min_acc;
  logic [5:0]              sec_acc;
  logic [2:0]              wday_acc;

  logic signed [26:0]      day_prod;
  logic signed [19:0]      zone_prod;
  logic [16:0]             divisor;
  logic [24:0]             dividend;
  logic [25:0]             recip;
  logic [50:0]             recip_prod;
  logic [15:0]             quo_est;
  logic [32:0]             back_prod;
  logic [EpochW-1:0]       rem_low;
  logic                    leap;
  logic [8:0]              ylen;
  logic [4:0]              mlen;
  logic                    ge;
  logic                    out_busy;

  // Day and zone shifts.
  assign day_prod = day_offset * DAY_SECS;
  assign zone_prod = zone * ZONE_UNIT_SECS;

  // Divisor, pre-shifted dividend, reciprocal and quotient slice for the selected divide.
  always_comb begin
    case (ctrl.div_sel)
      DIV_DAY: begin
        divisor = DIV_DAY_VAL;
        dividend = rem[31:7];
        recip = RECIP_DAY;
      end
      DIV_WEEK: begin
        divisor = DIV_WEEK_VAL;
        dividend = rem[24:0];
        recip = RECIP_WEEK;
      end
      DIV_HOUR: begin
        divisor = DIV_HOUR_VAL;
        dividend = {4'b0, rem[24:4]};
        recip = RECIP_HOUR;
      end
      DIV_MIN: begin
        divisor = DIV_MIN_VAL;
        dividend = {2'b0, rem[24:2]};
        recip = RECIP_MIN;
      end
      default: begin
        divisor = DIV_DAY_VAL;
        dividend = rem[31:7];
        recip = RECIP_DAY;
      end
    endcase
  end

  assign recip_prod = dividend * recip;

  always_comb begin
    case (ctrl.div_sel)
      DIV_DAY:  quo_est = recip_prod[50:35];
      DIV_WEEK: quo_est = recip_prod[34:19];
      DIV_HOUR: quo_est = recip_prod[36:21];
      DIV_MIN:  quo_est = recip_prod[29:14];
      default:  quo_est = recip_prod[50:35];
    endcase
  end

  // Remainder of the last divide, from the registered quotient.
  assign back_prod = quo * divisor;
  assign rem_low = rem - back_prod[EpochW-1:0];

  // Year and month lengths.
  assign leap = (yr_acc[1:0] == 2'b00);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = month_len(mon_acc, leap);

  // Compare that decides subtraction and loop exit.
  always_comb begin
    case (ctrl.op)
      OP_YEAR:  ge = (rem >= {23'b0, ylen});
      OP_MONTH: ge = (rem >= {27'b0, mlen});
      default:  ge = 1'b0;
    endcase
  end

  assign out_busy = out_valid & ~out_ready;
  assign status = '{ge: ge, out_busy: out_busy};

  // Control state: zone register and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      zone <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        zone <= zone_offset;
      end
      // A new result refills the register; otherwise a taken result empties it.
      if (ctrl.op == OP_EMIT && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers, updated by the operation of each step.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (in_valid) begin
          rem <= epoch_seconds + 32'(day_prod);
        end
      end
      OP_ADDZ: begin
        rem <= rem + 32'(zone_prod);
      end
      OP_DIV: begin
        quo <= quo_est;
      end
      OP_DAYS: begin
        days <= quo;
        secs <= rem_low[16:0];
        rem <= {16'b0, quo + WEEKDAY_BIAS};
      end
      OP_WDAY: begin
        wday_acc <= rem_low[2:0];
        rem <= {15'b0, secs};
      end
      OP_HOUR: begin
        hour_acc <= quo[4:0];
        rem <= rem_low;
      end
      OP_MINSEC: begin
        min_acc <= quo[5:0];
        sec_acc <= rem_low[5:0];
        rem <= {16'b0, days};
        yr_acc <= BASE_YEAR;
        mon_acc <= 4'd1;
      end
      OP_YEAR: begin
        if (ge) begin
          rem <= rem - {23'b0, ylen};
          yr_acc <= yr_acc + 1'b1;
        end
      end
      OP_MONTH: begin
        if (ge) begin
          rem <= rem - {27'b0, mlen};
          mon_acc <= mon_acc + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register, loaded once the previous item has been taken.
  always_ff @(posedge clk) begin
    if (ctrl.op == OP_EMIT && !out_busy) begin
      year <= yr_acc;
      month <= mon_acc;
      day <= rem[4:0] + 5'd1;
      hour <= hour_acc;
      minute <= min_acc;
      second <= sec_acc;
      weekday <= wday_acc;
    end
  end

endmodule

@@ hdl/epoch_to_local_calendar_top.sv @@
// Epoch seconds to local calendar date and time converter, top level.
// Depends on e2lc_pkg, e2lc_seq and e2lc_dp.
//
// Converts a 32-bit count of seconds since 1970-01-01 UTC, shifted by a signed
// day offset and by the zone_offset register (units of 900 s), into year, month,
// day, hour, minute, second and weekday (0 is Monday). The shifted count wraps
// modulo 2^32, and every year divisible by four counts as a leap year. One item
// is converted at a time by a small microcoded sequencer over a shared divider
// that multiplies by a constant reciprocal, one divide per step. An item passes
// through the shift, division and hand-off steps plus a year walk and a month
// walk that repeat a step for each elapsed year and month, so the next item is
// accepted soonest for early dates and latest for items late in 2105. A
// finished result sits in an output register while the next item is accepted
// and converted; if it has not been taken when the next result is ready, the
// sequencer waits. The zone register may be written whenever no item is in
// flight; cfg_ready is high outside reset.
module epoch_to_local_calendar_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic signed [e2lc_pkg::ZoneW-1:0]   zone_offset,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [e2lc_pkg::EpochW-1:0]         epoch_seconds,
  input  logic signed [e2lc_pkg::DayOffW-1:0] day_offset,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [e2lc_pkg::YearW-1:0]          year,
  output logic [3:0]                          month,
  output logic [4:0]                          day,
  output logic [4:0]                          hour,
  output logic [5:0]                          minute,
  output logic [5:0]                          second,
  output logic [2:0]                          weekday
);
  import e2lc_pkg::*;

  ctrl_word_t ctrl;
  status_t    status;

  // An item is taken only at the load step of the program.
  assign in_ready = (ctrl.op == OP_LOAD) & ~rst;
  assign cfg_ready = ~rst;

  e2lc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl)
  );

  e2lc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .zone_offset   (zone_offset),
    .in_valid      (in_valid),
    .epoch_seconds (epoch_seconds),
    .day_offset    (day_offset),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second),
    .weekday       (weekday)
  );

endmodule

@@ tb/tb_epoch_to_local_calendar_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for epoch_to_local_calendar_top: directed vectors, then random items.
// Depends on e2lc_pkg for port widths; the block's own hdl files must be compiled first.
module tb_epoch_to_local_calendar_top;

  localparam int SecsPerDay = 86400;
  localparam int SecsPerHour = 3600;
  localparam int SecsPerMin = 60;
  localparam int ZoneUnitSecs = 900;
  localparam int FirstYear = 1970;
  localparam int FirstWeekday = 3;
  localparam int MonthDays[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
  localparam int MaxWait = 12;
  localparam int SettleCycles = 4;
  localparam int LatencyCycles = 250;
  localparam int CycleLimit = 1000000;
  localparam int RandomPhases = 6;
  localparam int ItemsPerPhase = 125;

  typedef logic signed [e2lc_pkg::ZoneW-1:0] zone_t;
  typedef logic signed [e2lc_pkg::DayOffW-1:0] days_t;

  // One converted timestamp, as the block reports it.
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } stamp_t;

  // A directed vector; the stamp is used only when it is known by hand.
  typedef struct packed {
    logic [31:0] secs;
    days_t       days_ahead;
    zone_t       zone;
    logic        known;
    stamp_t      stamp;
  } vector_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  zone_t zone_offset = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] epoch_seconds = '0;
  days_t day_offset = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [11:0] year;
  logic [3:0] month;
  logic [4:0] day;
  logic [4:0] hour;
  logic [5:0] minute;
  logic [5:0] second;
  logic [2:0] weekday;

  stamp_t expected_stamps[$];
  vector_t vectors[$];
  zone_t zone_reg = '0;
  bit no_idle = 1'b0;
  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int zone_writes = 0;
  int cycle_count = 0;

  epoch_to_local_calendar_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .zone_offset  (zone_offset),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .epoch_seconds(epoch_seconds),
    .day_offset   (day_offset),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .year         (year),
    .month        (month),
    .day          (day),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .weekday      (weekday)
  );

  // Local calendar time for a shifted epoch count; every fourth year is a leap year.
  function automatic stamp_t local_time_of(input logic [31:0] secs, input days_t days_ahead,
                                           input zone_t zone);
    longint shift;
    logic [31:0] t;
    int unsigned day_num;
    int unsigned clock_secs;
    int unsigned yr;
    int unsigned mon;
    int unsigned span;
    stamp_t s;
    shift = longint'(days_ahead) * SecsPerDay + longint'(zone) * ZoneUnitSecs;
    t = secs + shift[31:0];
    day_num = t / SecsPerDay;
    clock_secs = t - day_num * SecsPerDay;
    s.weekday = 3'((day_num + FirstWeekday) % 7);
    // Strip whole years, then whole months.
    yr = FirstYear;
    span = 365 + (yr % 4 == 0);
    while (day_num >= span) begin
      day_num -= span;
      yr++;
      span = 365 + (yr % 4 == 0);
    end
    mon = 1;
    for (int m = 0; m < 12; m++) begin
      span = MonthDays[m] + ((m == 1) && (yr % 4 == 0));
      if (day_num < span) break;
      day_num -= span;
      mon++;
    end
    s.year = 12'(yr);
    s.month = 4'(mon);
    s.day = 5'(day_num + 1);
    s.hour = 5'(clock_secs / SecsPerHour);
    s.minute = 6'((clock_secs % SecsPerHour) / SecsPerMin);
    s.second = 6'(clock_secs % SecsPerMin);
    return s;
  endfunction

  // Cycles a side waits before its next item.
  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, MaxWait);
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // Offer one item after a gap and record its expected timestamp once accepted.
  task automatic send_item(input logic [31:0] secs, input days_t days_ahead, input int gap,
                           input logic known, input stamp_t stamp);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    epoch_seconds <= secs;
    day_offset <= days_ahead;
    do @(posedge clk); while (!in_ready);
    expected_stamps.push_back(known ? stamp : local_time_of(secs, days_ahead, zone_reg));
    items_sent++;
  endtask

  // Let the block drain, then write the zone register.
  task automatic set_zone(input zone_t zone);
    in_valid <= 1'b0;
    while (expected_stamps.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    zone_offset <= zone;
    do @(posedge clk); while (!cfg_ready);
    zone_reg = zone;
    zone_writes++;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
           expected_stamps.size());
    $display("simulation failed");
    $finish;
  end

  // Result side: random back-pressure and a field-by-field check of each item.
  initial begin
    int stall;
    stamp_t want;
    stall = draw_wait();
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (expected_stamps.size() == 0) begin
          $error("result with no item outstanding: %0d-%0d-%0d %0d:%0d:%0d", year, month,
                 day, hour, minute, second);
          errors++;
        end else begin
          want = expected_stamps.pop_front();
          compare_field("year", 32'(want.year), 32'(year));
          compare_field("month", 32'(want.month), 32'(month));
          compare_field("day", 32'(want.day), 32'(day));
          compare_field("hour", 32'(want.hour), 32'(hour));
          compare_field("minute", 32'(want.minute), 32'(minute));
          compare_field("second", 32'(want.second), 32'(second));
          compare_field("weekday", 32'(want.weekday), 32'(weekday));
          results_checked++;
        end
        stall = draw_wait();
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus: directed vectors grouped by zone, then random phases.
  initial begin
    zone_t zone;
    logic [31:0] secs;
    days_t days_ahead;
    int unsigned yr;
    int directed_count;

    // Zone 0 first so that the reset value of the register is exercised.
    vectors.push_back(vector_t'{32'd0, 9'sd0, 7'sd0, 1'b1,
                                stamp_t'{12'd1970, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd3}});
    vectors.push_back(vector_t'{32'd86399, 9'sd0, 7'sd0, 1'b1,
                                stamp_t'{12'd1970, 4'd1, 5'd1, 5'd23, 6'd59, 6'd59, 3'd3}});
    // Top of the count; 2100 being a leap year pulls this back to 6 February.
    vectors.push_back(vector_t'{32'hFFFFFFFF, 9'sd0, 7'sd0, 1'b1,
                                stamp_t'{12'd2106, 4'd2, 5'd6, 5'd6, 6'd28, 6'd15, 3'd6}});
    // Shift before 1970 and past the top of the count wrap around.
    vectors.push_back(vector_t'{32'd0, -9'sd1, 7'sd0, 1'b0, '0});
    vectors.push_back(vector_t'{32'hFFFFFFFF, 9'sd1, 7'sd0, 1'b0, '0});
    vectors.push_back(vector_t'{32'd0, 9'sh100, 7'sd0, 1'b0, '0});
    vectors.push_back(vector_t'{32'd0, 9'sd255, 7'sd0, 1'b0, '0});
    // Noon on 28 February 2100 plus one day lands on 29 February, a Monday.
    vectors.push_back(vector_t'{32'd4107499200, 9'sd1, 7'sd0, 1'b1,
                                stamp_t'{12'd2100, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0, 3'd0}});
    vectors.push_back(vector_t'{32'd951782400, 9'sd0, 7'sd0, 1'b0, '0});
    vectors.push_back(vector_t'{32'd94694399, 9'sd0, 7'sd0, 1'b0, '0});
    vectors.push_back(vector_t'{32'd4102444799, 9'sd0, 7'sd0, 1'b0, '0});
    vectors.push_back(vector_t'{32'h7FFFFFFF, 9'sd0, 7'sd0, 1'b0, '0});
    vectors.push_back(vector_t'{32'hAAAAAAAA, 9'sh0AA, 7'sd0, 1'b0, '0});
    vectors.push_back(vector_t'{32'h55555555, 9'sh155, 7'sd0, 1'b0, '0});
    // Zone extremes, including patterns outside the nominal range.
    vectors.push_back(vector_t'{32'd0, 9'sd0, 7'sh40, 1'b0, '0});
    vectors.push_back(vector_t'{32'd0, 9'sh100, 7'sh40, 1'b0, '0});
    vectors.push_back(vector_t'{32'hFFFFFFFF, 9'sd255, 7'sh40, 1'b0, '0});
    vectors.push_back(vector_t'{32'hFFFFFFFF, 9'sd255, 7'sd63, 1'b0, '0});
    vectors.push_back(vector_t'{32'hFFFFFFFF, 9'sd0, 7'sd63, 1'b0, '0});
    vectors.push_back(vector_t'{32'd0, 9'sh100, 7'sd63, 1'b0, '0});
    vectors.push_back(vector_t'{32'd12345678, -9'sd3, -7'sd56, 1'b0, '0});
    vectors.push_back(vector_t'{32'd4102444799, 9'sd2, 7'sd56, 1'b0, '0});

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (vectors[i]) begin
      if (vectors[i].zone != zone_reg) set_zone(vectors[i].zone);
      send_item(vectors[i].secs, vectors[i].days_ahead, draw_wait(), vectors[i].known,
                vectors[i].stamp);
    end
    directed_count = items_sent;

    // Random phases, each under its own zone; every third phase runs without idling.
    for (int p = 0; p < RandomPhases; p++) begin
      no_idle = (p % 3 == 1);
      zone = zone_t'($urandom_range(0, 127));
      set_zone(zone);
      repeat (ItemsPerPhase) begin
        case ($urandom_range(0, 7))
          0: secs = $urandom_range(0, 300 * SecsPerDay);
          1: secs = 32'hFFFFFFFF - $urandom_range(0, 300 * SecsPerDay);
          2, 3: begin
            // Near the start of a year, where the year and month walks turn over.
            yr = $urandom_range(1970, 2106);
            secs = ((yr - 1970) * 365 + (yr - 1969) / 4) * SecsPerDay
                   + $urandom_range(0, 2 * SecsPerDay) - SecsPerDay;
          end
          default: secs = $urandom();
        endcase
        days_ahead = days_t'($urandom_range(0, 511));
        if ($urandom_range(0, 3) == 0) days_ahead = '0;
        send_item(secs, days_ahead, draw_wait(), 1'b0, '0);
      end
    end

    // Drain and give the block time to show any stray result.
    in_valid <= 1'b0;
    while (expected_stamps.size() != 0) @(posedge clk);
    repeat (LatencyCycles) @(posedge clk);

    $display("Converted %0d items (%0d directed, %0d random) under %0d zone writes.",
             items_sent, directed_count, items_sent - directed_count, zone_writes);
    $display("Checked %0d timestamps field by field, %0d mismatches.", results_checked, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
